### hw/rtl/mdl_pkg.sv
// package for the modulated delay line
// shared constants, control word types and register indexes; no dependencies
package mdl_pkg;

   // default sizes
   localparam int BUFFER_DEF         = 4096;
   localparam int CHANNELS_DEF       = 2;
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int SINE_ROM_DEPTH_DEF = 1024;

   // register fields
   localparam int DEPTH_W    = 12;
   localparam int STEP_W     = 32;
   localparam int PHASE_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // sine magnitude, q1.23 without sign
   localparam int SINE_W = 23;
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREDELAY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP     = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic rom_rd;
      logic mul;
      logic dly_wr;
      logic rd1;
      logic rd2;
      logic mix_load;
   } mdl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
   } mdl_status_type;

endpackage

### hw/rtl/modulated_delay_line.sv
// Sine-modulated fractional delay (chorus/flanger) for up to CHANNELS
// interleaved channels. A word is accepted in idle and its result is loaded
// into the output register after these steps: sine table read, depth multiply,
// delay sum and saturation with the line write, then two tap reads on the
// single read port of the line memory and the interpolation. The sequencer then
// returns to idle, so a new word is taken only once the previous one is through;
// a result still waiting in the output register holds the sequencer in
// its last step. The line memory needs no clearing
// pass: per-channel fill marks make never-written slots read as silence, so
// the block accepts words right after reset. csr_ready is always high;
// registers should only be written while no word is in flight.
// uses mdl_pkg, mdl_ctrl, mdl_datapath
module modulated_delay_line
   import mdl_pkg::*;
#(
   parameter int BUFFER         = BUFFER_DEF,
   parameter int CHANNELS       = CHANNELS_DEF,
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,  // sample_in
   input  logic                                req_tuser,  // channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]    rsp_tdata,  // sample_out
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [CSR_IDX_W-1:0]                csr_index,
   input  logic [CSR_DATA_W-1:0]               csr_data
);

   localparam int TD_W = ((SAMPLE_BITS + 7) / 8) * 8;

   mdl_cmd_type            cmd;
   mdl_status_type         status;
   logic [SAMPLE_BITS-1:0] rsp_sample;

   mdl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   mdl_datapath #(
      .BUFFER        (BUFFER),
      .CHANNELS      (CHANNELS),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .SINE_ROM_DEPTH(SINE_ROM_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_channel(req_tuser),
      .in_sample (req_tdata[SAMPLE_BITS-1:0]),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_sample(rsp_sample)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = TD_W'(rsp_sample);

endmodule

### hw/rtl/mdl_ram.sv
// generic ram, one write port and one registered read port
// no dependencies
module mdl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/mdl_sine_rom.sv
// quarter-wave sine table with registered read
// entries built at elaboration from a q2.30 taylor series; uses mdl_pkg
module mdl_sine_rom
   import mdl_pkg::*;
#(
   parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              rd_en,
   input  logic [$clog2(SINE_ROM_DEPTH+1)-1:0] rd_index,
   output logic [SINE_W-1:0]                 rd_value
);

   localparam int IW = $clog2(SINE_ROM_DEPTH + 1);

   // one entry: sin(pi/2*k/depth) in q1.23, rounded half up and capped
   function automatic logic [SINE_W-1:0] rom_entry(input int unsigned k);
      logic [63:0]        a;
      logic [63:0]        a2;
      logic [63:0]        term;
      logic [63:0]        prod;
      logic [63:0]        q;
      logic signed [63:0] sum;
      a    = (64'(k) * PI_HALF_Q30) / SINE_ROM_DEPTH;
      a2   = (a * a) >> 30;
      term = a;
      sum  = $signed(a);
      for (int n = 1; n <= 8; n++) begin
         prod = (term * a2) >> 30;
         unique case (n)
            1:       term = prod / 6;
            2:       term = prod / 20;
            3:       term = prod / 42;
            4:       term = prod / 72;
            5:       term = prod / 110;
            6:       term = prod / 156;
            7:       term = prod / 210;
            default: term = prod / 272;
         endcase
         if (n % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      q = ($unsigned(sum) + 64'd64) >> 7;
      if (q > 64'd8388607) begin
         q = 64'd8388607;
      end
      return q[SINE_W-1:0];
   endfunction

   logic [SINE_W-1:0] rom_tab [SINE_ROM_DEPTH+1];
   logic [SINE_W-1:0] rd_value_ff;

   // constant table
   for (genvar g = 0; g <= SINE_ROM_DEPTH; g++) begin : g_rom
      localparam logic [SINE_W-1:0] ENTRY = rom_entry(g);
      assign rom_tab[g] = ENTRY;
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_value_ff <= rom_tab[rd_index[IW-1:0]];
      end
   end

   assign rd_value = rd_value_ff;

endmodule

### hw/rtl/mdl_ctrl.sv
// sequencer for the modulated delay line
// walks one word through the datapath steps; uses mdl_pkg
module mdl_ctrl
   import mdl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  mdl_status_type status,
   output mdl_cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SINE  = 7'b0000010,
      ST_DEPTH = 7'b0000100,
      ST_DELAY = 7'b0001000,
      ST_ADDR  = 7'b0010000,
      ST_READ2 = 7'b0100000,
      ST_MIX   = 7'b1000000
   } mdl_state_type;

   mdl_state_type state_ff;
   mdl_state_type state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SINE;
            end
         end
         ST_SINE: begin
            cmd.rom_rd = 1'b1;
            state_in   = ST_DEPTH;
         end
         ST_DEPTH: begin
            cmd.mul  = 1'b1;
            state_in = ST_DELAY;
         end
         ST_DELAY: begin
            cmd.dly_wr = 1'b1;
            state_in   = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.rd1  = 1'b1;
            state_in = ST_READ2;
         end
         ST_READ2: begin
            cmd.rd2  = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            if (status.out_free) begin
               cmd.mix_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

### hw/rtl/mdl_datapath.sv
// datapath: registers, oscillator, delay arithmetic, line memory, output word
// uses mdl_pkg, mdl_ram and mdl_sine_rom
module mdl_datapath
   import mdl_pkg::*;
#(
   parameter int BUFFER         = BUFFER_DEF,
   parameter int CHANNELS       = CHANNELS_DEF,
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mdl_cmd_type            cmd,
   output mdl_status_type         status,
   input  logic                   csr_valid,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   in_channel,
   input  logic [SAMPLE_BITS-1:0] in_sample,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [SAMPLE_BITS-1:0] rsp_sample
);

   localparam int SB    = SAMPLE_BITS;
   localparam int AW    = $clog2(BUFFER);
   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MA_W  = $clog2(CHANNELS * BUFFER);
   localparam int IW    = $clog2(SINE_ROM_DEPTH + 1);
   localparam int DQ_W  = (AW + 8 > 21) ? AW + 8 : 21;
   localparam int PR_W  = DEPTH_W + 24;
   localparam int MX_W  = SB + 10;
   localparam logic [AW:0]      BUF_X  = (AW + 1)'(BUFFER);
   localparam logic [AW-1:0]    W_LAST = AW'(BUFFER - 1);
   localparam logic [MA_W-1:0]  BUF_M  = MA_W'(BUFFER);
   localparam logic [DQ_W-1:0]  DQ_SAT = DQ_W'((BUFFER - 2) * 256);
   localparam logic [IW-1:0]    ROM_D  = IW'(SINE_ROM_DEPTH);

   // configuration registers
   logic [DEPTH_W-1:0] depth_ff;
   logic [DEPTH_W-1:0] pre_ff;
   logic [STEP_W-1:0]  step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         pre_ff   <= '0;
         step_ff  <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_DEPTH) begin
            depth_ff <= csr_data[DEPTH_W-1:0];
         end
         if (csr_index == CSR_PREDELAY) begin
            pre_ff <= csr_data[DEPTH_W-1:0];
         end
         if (csr_index == CSR_STEP) begin
            step_ff <= csr_data[STEP_W-1:0];
         end
      end
   end

   // oscillator phase, write pointers and fill marks
   logic [PHASE_W-1:0] phase_ff;
   logic [AW-1:0]      wp_ff   [CHANNELS];
   logic [CHANNELS-1:0] wrap_ff;
   logic [CH_W-1:0]    ch_in;
   logic [AW-1:0]      w_cur;

   assign ch_in = (CHANNELS == 1) ? '0 : CH_W'(in_channel);
   assign w_cur = wp_ff[ch_in];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         wrap_ff  <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            wp_ff[c] <= '0;
         end
      end else if (cmd.accept) begin
         phase_ff <= phase_ff + step_ff;
         if (w_cur == W_LAST) begin
            wp_ff[ch_in]   <= '0;
            wrap_ff[ch_in] <= 1'b1;
         end else begin
            wp_ff[ch_in] <= w_cur + 1'b1;
         end
      end
   end

   // latch the word and the rom index
   logic [30+IW-1:0] idx_prod;
   logic [CH_W-1:0]  ch_ff;
   logic [SB-1:0]    smp_ff;
   logic [AW-1:0]    w_ff;
   logic             wrap_cur_ff;
   logic [1:0]       quad_ff;
   logic [IW-1:0]    idx_ff;

   assign idx_prod = (30 + IW)'(phase_ff[29:0]) * (30 + IW)'(SINE_ROM_DEPTH);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ch_ff       <= ch_in;
         smp_ff      <= in_sample;
         w_ff        <= w_cur;
         wrap_cur_ff <= wrap_ff[ch_in];
         quad_ff     <= phase_ff[31:30];
         idx_ff      <= idx_prod[30+IW-1:30];
      end
   end

   // sine lookup, mirrored in odd quadrants
   logic [IW-1:0]     rom_idx;
   logic [SINE_W-1:0] rom_val;

   assign rom_idx = quad_ff[0] ? (ROM_D - idx_ff) : idx_ff;

   mdl_sine_rom #(
      .SINE_ROM_DEPTH(SINE_ROM_DEPTH)
   ) u_rom (
      .clock   (clock),
      .rd_en   (cmd.rom_rd),
      .rd_index(rom_idx),
      .rd_value(rom_val)
   );

   // depth times offset sine
   logic [23:0]     sine_u;
   logic [PR_W-1:0] prod_ff;

   assign sine_u = quad_ff[1] ? (24'd8388608 - 24'(rom_val)) : (24'd8388608 + 24'(rom_val));

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= PR_W'(depth_ff) * PR_W'(sine_u);
      end
   end

   // delay in q.8 with saturation
   logic [DQ_W-1:0] dq_sum;
   logic [DQ_W-1:0] dq_sat;
   logic [AW-1:0]   dint_ff;
   logic [7:0]      frac_ff;

   assign dq_sum = DQ_W'(prod_ff >> 16) + DQ_W'({13'(pre_ff) + 13'd1, 8'd0});
   assign dq_sat = (dq_sum > DQ_SAT) ? DQ_SAT : dq_sum;

   always_ff @(posedge clock) begin
      if (cmd.dly_wr) begin
         dint_ff <= dq_sat[AW+7:8];
         frac_ff <= dq_sat[7:0];
      end
   end

   // tap addresses, modulo the line length
   logic [AW:0]   diff;
   logic [AW-1:0] r1;
   logic [AW-1:0] r2_ff;
   logic          v1_ff;
   logic          v2_ff;
   logic          v2;

   assign diff = {1'b0, w_ff} - {1'b0, dint_ff};
   assign r1   = diff[AW] ? AW'(diff + BUF_X) : diff[AW-1:0];
   assign v2   = wrap_cur_ff || (r2_ff < w_ff);

   always_ff @(posedge clock) begin
      if (cmd.rd1) begin
         r2_ff <= (r1 == '0) ? W_LAST : r1 - 1'b1;
         v1_ff <= wrap_cur_ff || (r1 < w_ff);
      end
      if (cmd.rd2) begin
         v2_ff <= v2;
      end
   end

   // line memory, channel-major
   logic [MA_W-1:0] base;
   logic [MA_W-1:0] wr_addr;
   logic [MA_W-1:0] rd_addr;
   logic [SB-1:0]   rd_data;

   assign base    = MA_W'(ch_ff) * BUF_M;
   assign wr_addr = base + MA_W'(w_ff);
   assign rd_addr = base + MA_W'(cmd.rd1 ? r1 : r2_ff);

   mdl_ram #(
      .WIDTH(SB),
      .DEPTH(CHANNELS * BUFFER)
   ) u_line (
      .clock  (clock),
      .wr_en  (cmd.dly_wr),
      .wr_addr(wr_addr),
      .wr_data(smp_ff),
      .rd_en  (cmd.rd1 | cmd.rd2),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // first tap, never-written entries read silence
   logic [SB-1:0] t1_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd2) begin
         t1_ff <= v1_ff ? rd_data : '0;
      end
   end

   // linear interpolation: t1 + f*(t2-t1), rounded
   logic signed [SB-1:0] t1_s;
   logic signed [SB-1:0] t2_s;
   logic signed [SB:0]   tdiff;
   logic signed [MX_W-1:0] mix;

   assign t1_s  = $signed(t1_ff);
   assign t2_s  = v2_ff ? $signed(rd_data) : '0;
   assign tdiff = (SB + 1)'(t2_s) - (SB + 1)'(t1_s);
   assign mix   = ($signed(MX_W'(t1_s)) <<< 8)
                + $signed(MX_W'(tdiff)) * $signed(MX_W'({1'b0, frac_ff}))
                + $signed(MX_W'(128));

   // output word register
   logic          out_valid_ff;
   logic [SB-1:0] out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.mix_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mix_load) begin
         out_ff <= mix[SB+7:8];
      end
   end

   assign status.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_sample      = out_ff;

`ifndef SYNTHESIS
   // saturated delay always lands inside the line
   assert property (@(posedge clock) disable iff (reset)
      cmd.rd1 |-> (dint_ff >= AW'(1)) && (dint_ff <= AW'(BUFFER - 2)))
      else $error("delay out of range");

   // the first tap never reads the slot being written
   assert property (@(posedge clock) disable iff (reset)
      cmd.rd1 |-> (r1 != w_ff))
      else $error("tap collides with write pointer");

   // a new word never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.mix_load |-> !(out_valid_ff && !rsp_tready))
      else $error("output word overwritten");

   // second tap follows the first read in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.rd1 |=> cmd.rd2)
      else $error("tap reads out of order");
`endif

endmodule

### verif/modulated_delay_line_tb.sv
// self-checking testbench for the modulated delay line
// drives sample words and register writes, predicts every output word
// depends on mdl_pkg and modulated_delay_line
module modulated_delay_line_tb
   import mdl_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUF   = BUFFER_DEF;
   localparam int CHN   = CHANNELS_DEF;
   localparam int ROMD  = SINE_ROM_DEPTH_DEF;
   localparam int N_RANDOM = 1750;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   modulated_delay_line u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   int          sine_tab[ROMD+1];
   int          line_mem[CHN*BUF];
   int unsigned wr_ptr[CHN];
   logic [31:0] lfo_phase;
   logic [11:0] depth_reg, predelay_reg;
   logic [31:0] step_reg;
   logic [23:0] expected_samples[$];
   int          error_count = 0;
   bit          hold_rx = 1'b0;
   bit          rx_quiet = 1'b0;
   bit          tx_quiet = 1'b0;

   // quarter sine entry from integer taylor series in q2.30
   function automatic int sine_entry(int unsigned k);
      longint unsigned a, a2, term, q;
      longint sum;
      a = (longint'(k) * PI_HALF_Q30) / ROMD;
      a2 = (a * a) >> 30;
      term = a;
      sum = a;
      for (int n = 1; n <= 8; n++) begin
         term = ((term * a2) >> 30) / longint'((2*n) * (2*n + 1));
         if (n % 2) sum -= term;
         else sum += term;
      end
      if (sum < 0) sum = 0;
      q = (longint'(sum) + 64) >> 7;
      if (q > 8388607) q = 8388607;
      return int'(q);
   endfunction

   function automatic int sine_at(logic [31:0] ph);
      int unsigned idx;
      int v;
      idx = int'((longint'(ph[29:0]) * ROMD) >> 30);
      v = ph[30] ? sine_tab[ROMD - idx] : sine_tab[idx];
      return ph[31] ? -v : v;
   endfunction

   // next delayed sample for one word; updates line, pointer and phase
   function automatic logic [23:0] chorus_sample(bit ch, logic [23:0] smp);
      int unsigned w, dint, frac, r1, r2;
      longint dq8, acc;
      int s;
      w = wr_ptr[ch];
      s = sine_at(lfo_phase);
      line_mem[ch*BUF + w] = int'($signed(smp));
      dq8 = (longint'(depth_reg) * (longint'(s) + 8388608)) >>> 16;
      dq8 += (longint'(predelay_reg) + 1) << 8;
      if (dq8 > longint'(BUF - 2) << 8) dq8 = longint'(BUF - 2) << 8;
      dint = int'(dq8 >>> 8);
      frac = int'(dq8 & 255);
      r1 = (w + BUF - dint) % BUF;
      r2 = (r1 + BUF - 1) % BUF;
      acc = longint'(256 - frac) * line_mem[ch*BUF + r1]
          + longint'(frac) * line_mem[ch*BUF + r2] + 128;
      acc = acc >>> 8;
      wr_ptr[ch] = (w + 1) % BUF;
      lfo_phase = lfo_phase + step_reg;
      return acc[23:0];
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
      unique case (idx)
         CSR_DEPTH:    depth_reg = value[11:0];
         CSR_PREDELAY: predelay_reg = value[11:0];
         CSR_STEP:     step_reg = value;
         default: ;
      endcase
   endtask

   // random idle gap on the sending side
   task automatic tx_gap();
      while (!tx_quiet && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
   endtask

   // send one word; fixed is nonzero when a typed expectation is given
   task automatic send_word(bit ch, logic [23:0] smp, bit fixed, logic [23:0] fixed_out);
      logic [23:0] pred;
      tx_gap();
      req_tuser <= ch;
      req_tdata <= smp;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pred = chorus_sample(ch, smp);
      if (fixed && pred !== fixed_out)
         report_mismatch($sformatf("typed %h vs predicted %h", fixed_out, pred));
      expected_samples.push_back(pred);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // result side: random ready, checked against the oldest expectation
   initial begin
      forever begin
         @(negedge clock);
         rsp_tready <= !hold_rx && (rx_quiet || $urandom_range(99) >= 23);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0)
            report_mismatch($sformatf("unexpected word %h", rsp_tdata));
         else begin
            logic [23:0] exp_word;
            exp_word = expected_samples.pop_front();
            if (rsp_tdata !== exp_word)
               report_mismatch($sformatf("sample_out %h, expected %h", rsp_tdata, exp_word));
         end
      end
   end

   // directed table
   typedef struct {
      bit ch;
      logic [23:0] smp;
      bit fixed;
      logic [23:0] out_word;
   } dir_row_type;

   dir_row_type dir_rows[] = '{
      '{1'b0, 24'h7FFFFF, 1'b1, 24'h000000},
      '{1'b0, 24'h800000, 1'b1, 24'h7FFFFF},
      '{1'b1, 24'h800000, 1'b1, 24'h000000},
      '{1'b1, 24'h7FFFFF, 1'b1, 24'h800000},
      '{1'b0, 24'h000001, 1'b1, 24'h800000},
      '{1'b0, 24'hFFFFFF, 1'b0, 24'h0},
      '{1'b1, 24'h123456, 1'b0, 24'h0},
      '{1'b1, 24'hABCDEF, 1'b0, 24'h0}
   };

   initial begin
      for (int k = 0; k <= ROMD; k++) sine_tab[k] = sine_entry(k);
      foreach (line_mem[i]) line_mem[i] = 0;
      foreach (wr_ptr[i]) wr_ptr[i] = 0;
      lfo_phase = '0;
      depth_reg = '0;
      predelay_reg = '0;
      step_reg = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero delay settings: one-sample echo
      foreach (dir_rows[i])
         send_word(dir_rows[i].ch, dir_rows[i].smp, dir_rows[i].fixed, dir_rows[i].out_word);
      drain();

      // saturated delay, fast oscillator, unused register index
      csr_write(CSR_DEPTH, 32'hFFFF_FFFE);
      csr_write(CSR_PREDELAY, 32'd4094);
      csr_write(CSR_STEP, 32'h8000_0000);
      csr_write(CSR_UNUSED, 32'hDEAD_BEEF);
      for (int i = 0; i < 8; i++) send_word(i[0], 24'($urandom), 1'b0, '0);
      drain();

      // random phases with several settings
      for (int ph = 0; ph < 6; ph++) begin
         unique case (ph)
            0: begin csr_write(CSR_DEPTH, 0); csr_write(CSR_PREDELAY, 0);
                      csr_write(CSR_STEP, 0); end
            1: begin csr_write(CSR_DEPTH, 4094); csr_write(CSR_PREDELAY, 0);
                      csr_write(CSR_STEP, 32'h8000_0000); end
            2: begin csr_write(CSR_DEPTH, $urandom_range(40)); csr_write(CSR_PREDELAY,
                      $urandom_range(20)); csr_write(CSR_STEP, $urandom); end
            3: begin csr_write(CSR_DEPTH, $urandom_range(4094));
                      csr_write(CSR_PREDELAY, $urandom_range(4094));
                      csr_write(CSR_STEP, $urandom_range(32'h0100_0000)); end
            4: begin csr_write(CSR_DEPTH, 7); csr_write(CSR_PREDELAY, 3);
                      csr_write(CSR_STEP, 32'h0123_4567); end
            default: begin csr_write(CSR_DEPTH, $urandom_range(4094));
                      csr_write(CSR_PREDELAY, $urandom_range(4094)); csr_write(CSR_STEP, $urandom); end
         endcase
         tx_quiet = (ph == 4);
         rx_quiet = (ph == 4);
         if (ph == 1) fork
            begin hold_rx = 1'b1; repeat (200) @(negedge clock); hold_rx = 1'b0; end
         join_none
         for (int i = 0; i < N_RANDOM / 6; i++) begin
            send_word(1'($urandom_range(1)), 24'($urandom), 1'b0, '0);
            // sender pause until everything is back
            if (ph == 2 && i == 100) begin
               req_tvalid <= 1'b0;
               @(negedge clock);
               while (expected_samples.size() != 0) @(negedge clock);
            end
         end
         tx_quiet = 1'b0;
         rx_quiet = 1'b0;
         drain();
      end

      if (error_count == 0)
         $display("modulated_delay_line_tb: clean");
      else
         $display("modulated_delay_line_tb: errors");
      $finish;
   end

   initial begin
      #2ms;
      $display("modulated_delay_line_tb: errors");
      $finish;
   end
endmodule
